// ===== rtl/core/bsim_pkg.sv =====
// ----------------------------------------------------------------------------
// bsim_pkg: shared types and codes of the bank switch IRQ mapper
// Item and view structs, opcode and register decode constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bsim_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_TICK    = 2'd1,
        OP_PRG     = 2'd2,
        OP_PATTERN = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic CFG_PATTERN_IS_RAM = 1'b1;

    localparam int CFG_WIDTH = 9;

    // write decode: address bits 15..12
    localparam logic [3:0] GRP_PRG_LO  = 4'h8;
    localparam logic [3:0] GRP_PRG_HI  = 4'h9;
    localparam logic [3:0] GRP_PAT_A   = 4'hA;
    localparam logic [3:0] GRP_PAT_B   = 4'hB;
    localparam logic [3:0] GRP_PAT_C   = 4'hC;
    localparam logic [3:0] GRP_PAT_D   = 4'hD;
    localparam logic [3:0] GRP_RELOAD  = 4'hE;
    localparam logic [3:0] GRP_CONTROL = 4'hF;

    // registers of the control group
    localparam logic [1:0] CREG_RELOAD = 2'd0;
    localparam logic [1:0] CREG_CTRL   = 2'd1;
    localparam logic [1:0] CREG_MIRROR = 2'd2;

    localparam logic [15:0] MASK_16 = 16'hffff;
    localparam logic [15:0] MASK_12 = 16'h0fff;
    localparam logic [15:0] MASK_8  = 16'h00ff;
    localparam logic [15:0] MASK_4  = 16'h000f;

    localparam logic [8:0] PRG_BANK_COUNT_RESET = 9'd16;

    typedef struct packed {
        op_t         opcode;
        logic [15:0] address;
        logic [7:0]  write_value;
    } item_t;

    // mapping state seen by the lookup logic
    typedef struct packed {
        logic [2:0][7:0] prg_windows;
        logic [7:0]      prg_last;
        logic [7:0][7:0] pattern_windows;
        logic            pattern_is_ram;
    } map_view_t;

    // status after the executing item
    typedef struct packed {
        logic       irq_line;
        logic [1:0] mirror_mode;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bsim_state.sv =====
// ----------------------------------------------------------------------------
// bsim_state: mapper register file
// Bank nibbles and windows, IRQ reload/counter/control, mirroring and
// configuration; executes register writes and cycle ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module bsim_state
    import bsim_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 exec,
    input  wire item_t                item,
    input  wire logic                 write_enable,
    input  wire logic                 register_index,
    input  wire logic [CFG_WIDTH-1:0] write_data,
    output map_view_t                 view,
    output status_t                   status_next
);

    logic [8:0]  bank_count_reg, bank_count_next;
    logic        is_ram_reg, is_ram_next;
    logic [3:0]  prg_nib_reg [6];
    logic [3:0]  prg_nib_next [6];
    logic [3:0]  pat_nib_reg [16];
    logic [3:0]  pat_nib_next [16];
    logic [7:0]  prg_win_reg [3];
    logic [7:0]  prg_win_next [3];
    logic [7:0]  pat_win_reg [8];
    logic [7:0]  pat_win_next [8];
    logic [15:0] reload_reg, reload_next;
    logic [15:0] count_reg, count_next;
    logic [3:0]  ctrl_reg, ctrl_next;
    logic [15:0] mask_reg, mask_next;
    logic        flag_reg, flag_next;
    logic [1:0]  mirror_reg, mirror_next;

    always_comb
    begin
        logic [3:0]  group;
        logic [1:0]  sel;
        logic [3:0]  nib;
        logic [1:0]  gi;
        logic [3:0]  pbase;
        logic [15:0] masked;
        logic [15:0] low;
        group  = item.address[15:12];
        sel    = item.address[1:0];
        nib    = item.write_value[3:0];
        gi     = 2'(group - GRP_PAT_A);
        pbase  = {gi, 2'b00};
        masked = count_reg & mask_reg;
        low    = (masked - 16'd1) & mask_reg;

        bank_count_next = bank_count_reg;
        is_ram_next     = is_ram_reg;
        prg_nib_next    = prg_nib_reg;
        pat_nib_next    = pat_nib_reg;
        prg_win_next    = prg_win_reg;
        pat_win_next    = pat_win_reg;
        reload_next     = reload_reg;
        count_next      = count_reg;
        ctrl_next       = ctrl_reg;
        mask_next       = mask_reg;
        flag_next       = flag_reg;
        mirror_next     = mirror_reg;

        if (exec)
        begin
            unique case (item.opcode)
                OP_WRITE:
                begin
                    unique case (group)
                        GRP_PRG_LO:
                        begin
                            prg_nib_next[{1'b0, sel}] = nib;
                            prg_win_next[0] = {prg_nib_next[1], prg_nib_next[0]};
                            prg_win_next[1] = {prg_nib_next[3], prg_nib_next[2]};
                        end
                        GRP_PRG_HI:
                        begin
                            // program RAM control registers are dropped
                            if (!sel[1])
                            begin
                                prg_nib_next[{2'b10, sel[0]}] = nib;
                                prg_win_next[2] = {prg_nib_next[5], prg_nib_next[4]};
                            end
                        end
                        GRP_PAT_A, GRP_PAT_B, GRP_PAT_C, GRP_PAT_D:
                        begin
                            pat_nib_next[{gi, sel}] = nib;
                            pat_win_next[{gi, 1'b0}] =
                                {pat_nib_next[pbase + 4'd1], pat_nib_next[pbase]};
                            pat_win_next[{gi, 1'b1}] =
                                {pat_nib_next[pbase + 4'd3], pat_nib_next[pbase + 4'd2]};
                        end
                        GRP_RELOAD:
                        begin
                            reload_next[{sel, 2'b00} +: 4] = nib;
                        end
                        GRP_CONTROL:
                        begin
                            unique case (sel)
                                CREG_RELOAD:
                                begin
                                    count_next = reload_reg;
                                    flag_next  = 1'b0;
                                end
                                CREG_CTRL:
                                begin
                                    ctrl_next = nib;
                                    priority if (item.write_value[3:1] == 3'b000)
                                        mask_next = MASK_16;
                                    else if (item.write_value[3:1] == 3'b001)
                                        mask_next = MASK_12;
                                    else if (item.write_value[3:2] == 2'b01)
                                        mask_next = MASK_8;
                                    else
                                        mask_next = MASK_4;
                                    flag_next = 1'b0;
                                end
                                CREG_MIRROR:
                                begin
                                    mirror_next = item.write_value[1:0];
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_TICK:
                begin
                    // decrement only the masked field, wrapping inside it
                    count_next = (count_reg & ~mask_reg) | low;
                    if ((masked == 16'd0) && ctrl_reg[0])
                        flag_next = 1'b1;
                end
                OP_PRG, OP_PATTERN:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (write_enable)
        begin
            unique case (register_index)
                CFG_PRG_BANK_COUNT:
                begin
                    bank_count_next = write_data;
                    prg_win_next[2] = 8'(write_data - 9'd2);
                end
                CFG_PATTERN_IS_RAM:
                begin
                    is_ram_next = write_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_count_reg <= PRG_BANK_COUNT_RESET;
            is_ram_reg     <= 1'b0;
            for (int i = 0; i < 6; i++)
                prg_nib_reg[i] <= 4'd0;
            for (int i = 0; i < 16; i++)
                pat_nib_reg[i] <= 4'd0;
            prg_win_reg[0] <= 8'd0;
            prg_win_reg[1] <= 8'd1;
            prg_win_reg[2] <= 8'(PRG_BANK_COUNT_RESET - 9'd2);
            for (int i = 0; i < 8; i++)
                pat_win_reg[i] <= 8'(i);
            reload_reg <= 16'd0;
            count_reg  <= 16'd0;
            ctrl_reg   <= 4'd0;
            mask_reg   <= 16'd0;
            flag_reg   <= 1'b0;
            mirror_reg <= 2'd0;
        end
        else
        begin
            bank_count_reg <= bank_count_next;
            is_ram_reg     <= is_ram_next;
            prg_nib_reg    <= prg_nib_next;
            pat_nib_reg    <= pat_nib_next;
            prg_win_reg    <= prg_win_next;
            pat_win_reg    <= pat_win_next;
            reload_reg     <= reload_next;
            count_reg      <= count_next;
            ctrl_reg       <= ctrl_next;
            mask_reg       <= mask_next;
            flag_reg       <= flag_next;
            mirror_reg     <= mirror_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            view.prg_windows[i] = prg_win_reg[i];
        for (int i = 0; i < 8; i++)
            view.pattern_windows[i] = pat_win_reg[i];
        view.prg_last       = 8'(bank_count_reg - 9'd1);
        view.pattern_is_ram = is_ram_reg;
    end

    assign status_next.irq_line    = flag_next;
    assign status_next.mirror_mode = mirror_next;

endmodule

`default_nettype wire

// ===== rtl/core/bsim_lookup.sv =====
// ----------------------------------------------------------------------------
// bsim_lookup: bank lookup
// Maps a program address at 8000h and up, or a pattern address, to its bank number; 0 otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module bsim_lookup
    import bsim_pkg::*;
(
    input  wire item_t     item,
    input  wire map_view_t view,
    output logic [7:0]     bank
);

    logic [1:0] win;
    logic [2:0] slot;

    assign win  = item.address[14:13];
    assign slot = item.address[12:10];

    always_comb
    begin
        bank = 8'd0;
        unique case (item.opcode)
            OP_PRG:
            begin
                if (item.address[15])
                begin
                    // top window is fixed to the last bank
                    if (win == 2'd3)
                        bank = view.prg_last;
                    else
                        bank = view.prg_windows[win];
                end
            end
            OP_PATTERN:
            begin
                if (view.pattern_is_ram)
                    bank = {5'd0, slot};
                else
                    bank = view.pattern_windows[slot];
            end
            OP_WRITE, OP_TICK:
            begin
                bank = 8'd0;
            end
            default:
            begin
                bank = 8'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/bank_switch_irq_mapper.sv =====
// ----------------------------------------------------------------------------
// bank_switch_irq_mapper: cartridge bank mapper with CPU-cycle IRQ counter
// Executes register writes, cycle ticks and bank lookups, one result each.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    opcode, address, write_value
//  out      out_valid / out_ready  bank_number, irq_line, mirror_mode
//  config   write_enable           register_index, write_data
//
//  One item per cycle sustained while out_ready stays high; an item goes
//  through the input register, the single execute step and the result
//  register. The input register advances whenever the result register is
//  empty or being taken, so a stalled result holds at most one more item in
//  flight. Reset restores all mapper state; config writes skip the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_switch_irq_mapper
    import bsim_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           opcode,
    input  wire logic [15:0]          address,
    input  wire logic [7:0]           write_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                bank_number,
    output logic                      irq_line,
    output logic [1:0]                mirror_mode,
    input  wire logic                 write_enable,
    input  wire logic                 register_index,
    input  wire logic [CFG_WIDTH-1:0] write_data
);

    item_t     item_reg;
    logic      item_valid_reg;
    logic      exec;
    map_view_t view;
    status_t   status_next;
    logic [7:0] bank;
    logic      out_valid_reg;
    logic [7:0] bank_reg;
    status_t   status_reg;

    assign exec     = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || exec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (exec)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.opcode      <= op_t'(opcode);
            item_reg.address     <= address;
            item_reg.write_value <= write_value;
        end
        if (exec)
        begin
            bank_reg   <= bank;
            status_reg <= status_next;
        end
    end

    bsim_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .exec           (exec),
        .item           (item_reg),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data),
        .view           (view),
        .status_next    (status_next)
    );

    bsim_lookup u_lookup (
        .item (item_reg),
        .view (view),
        .bank (bank)
    );

    assign out_valid   = out_valid_reg;
    assign bank_number = bank_reg;
    assign irq_line    = status_reg.irq_line;
    assign mirror_mode = status_reg.mirror_mode;

endmodule

`default_nettype wire
